/* design/sequential_record_list_unit_assert.svh */
// assertion macros for the record list unit
`ifndef SEQUENTIAL_RECORD_LIST_UNIT_ASSERT_SVH
`define SEQUENTIAL_RECORD_LIST_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// property checked at every edge outside reset
`define SRLU_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("sequential_record_list_unit: assertion failed");
// condition in one cycle implies a property in the next
`define SRLU_ASSERT_NEXT(lbl, cond, nxt) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (nxt)) \
      else $error("sequential_record_list_unit: next-cycle check failed");
`else
`define SRLU_ASSERT(lbl, prop)
`define SRLU_ASSERT_NEXT(lbl, cond, nxt)
`endif
`endif

/* design/srl_pkg.sv */
package srl_pkg;

   localparam int ACT_W     = 3;
   localparam int KEY_W     = 31;
   localparam int PAY_W     = 64;
   localparam int POS_W     = 7;
   localparam int CNT_OUT_W = 7;

   localparam logic [ACT_W-1:0] ACT_APPEND    = 3'd0;
   localparam logic [ACT_W-1:0] ACT_INSERT    = 3'd1;
   localparam logic [ACT_W-1:0] ACT_RM_FRONT  = 3'd2;
   localparam logic [ACT_W-1:0] ACT_RM_END    = 3'd3;
   localparam logic [ACT_W-1:0] ACT_READ      = 3'd4;
   localparam logic [ACT_W-1:0] ACT_FIND      = 3'd5;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [PAY_W-1:0] payload;
   } rec_type;

endpackage

/* design/srl_req_if.sv */
interface srl_req_if;
   import srl_pkg::*;

   logic             valid;
   logic             ready;
   logic [ACT_W-1:0] action;
   logic [KEY_W-1:0] key;
   logic [PAY_W-1:0] payload;
   logic [POS_W-1:0] position;

   modport source (output valid, action, key, payload, position, input ready);
   modport sink   (input valid, action, key, payload, position, output ready);

endinterface

/* design/srl_rsp_if.sv */
interface srl_rsp_if;
   import srl_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 status;
   logic [KEY_W-1:0]     found_key;
   logic [PAY_W-1:0]     found_payload;
   logic [CNT_OUT_W-1:0] count;
   logic                 full_res;
   logic                 empty_res;

   modport source (output valid, status, found_key, found_payload, count, full_res,
                   empty_res, input ready);
   modport sink   (input valid, status, found_key, found_payload, count, full_res,
                   empty_res, output ready);

endinterface

/* design/srl_store.sv */
module srl_store #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic            clock,
   input  logic            we,
   input  logic [AW-1:0]   waddr,
   input  srl_pkg::rec_type wdata,
   input  logic            re,
   input  logic [AW-1:0]   raddr,
   output srl_pkg::rec_type rdata
);
   import srl_pkg::*;

   rec_type mem [DEPTH];
   rec_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* design/sequential_record_list_unit.sv */
// Ordered list of up to CAPACITY records (31-bit key, 64-bit payload).
// req_chan carries one request per transaction: append, insert at front,
// remove front, remove end, read by 1-based position, or find by key
// (the match nearest the end wins). rsp_chan returns exactly one result
// per request with status, the record read or found, and the count and
// full/empty flags after the request.
// Records sit in a single memory used as a ring: a head pointer
// makes front insert and front remove one memory write or none at all.
// From accept, append, insert, remove and unknown codes go straight to the
// result stage (ST_POST); a read passes through ST_READ first; a find
// examines the records one by one in ST_SCAN, from the end toward the front.
// A new request is taken the cycle after the previous result moves to the
// output register. A find reads its records through the one read port.
// Reset (synchronous) empties the list at once; memory contents are left
// as they are. If the receiver stalls, the result holds in the output
// register and the next request may still be accepted and processed; it
// then waits for the output register to free before its result loads.
module sequential_record_list_unit #(
   parameter int CAPACITY = 64
) (
   input logic       clock,
   input logic       reset,
   srl_req_if.sink   req_chan,
   srl_rsp_if.source rsp_chan
);
   import srl_pkg::*;

   `include "sequential_record_list_unit_assert.svh"

   localparam int IDXW = $clog2(CAPACITY);
   localparam int CNTW = $clog2(CAPACITY + 1);
   localparam int CMPW = (CNTW > POS_W) ? CNTW : POS_W;

   localparam logic [CNTW-1:0] CAP_CNT  = CNTW'(CAPACITY);
   localparam logic [IDXW:0]   CAP_WRAP = (IDXW + 1)'(CAPACITY);
   localparam logic [IDXW-1:0] LAST_IDX = IDXW'(CAPACITY - 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;
   localparam logic [1:0] ST_POST = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic [IDXW-1:0]      head_ff, head_in;
   logic [CNTW-1:0]      count_ff, count_in;
   logic [IDXW-1:0]      idx_ff, idx_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic                 res_status_ff, res_status_in;
   rec_type              res_rec_ff, res_rec_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_status_ff, rsp_status_in;
   rec_type              rsp_rec_ff, rsp_rec_in;
   logic [CNT_OUT_W-1:0] rsp_count_ff, rsp_count_in;
   logic                 rsp_full_ff, rsp_full_in;
   logic                 rsp_empty_ff, rsp_empty_in;

   logic                 mem_we;
   logic [IDXW-1:0]      mem_waddr;
   rec_type              mem_wdata;
   logic                 mem_re;
   logic [IDXW-1:0]      mem_raddr;
   rec_type              mem_rdata;

   logic                 req_fire;
   logic                 out_free;
   logic                 out_load;
   logic [POS_W-1:0]     pos_m1;
   logic [IDXW-1:0]      pos_idx;
   logic [IDXW-1:0]      last_idx;
   logic                 pos_ok;

   // logical index to memory address, value stays below twice the depth
   function automatic logic [IDXW-1:0] phys(input logic [IDXW-1:0] base,
                                            input logic [IDXW-1:0] ofs);
      logic [IDXW:0] sum;
      sum = {1'b0, base} + {1'b0, ofs};
      if (sum >= CAP_WRAP) begin
         sum = sum - CAP_WRAP;
      end
      return sum[IDXW-1:0];
   endfunction

   srl_store #(
      .DEPTH (CAPACITY),
      .AW    (IDXW)
   ) u_store (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign out_load       = (state_ff == ST_POST) && out_free;

   assign pos_m1   = req_chan.position - POS_W'(1);
   assign pos_idx  = IDXW'(pos_m1);
   assign last_idx = IDXW'(count_ff - CNTW'(1));
   assign pos_ok   = (req_chan.position != '0) &&
                     (CMPW'(req_chan.position) <= CMPW'(count_ff));

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      key_in        = key_ff;
      res_status_in = res_status_ff;
      res_rec_in    = res_rec_ff;
      mem_we        = 1'b0;
      mem_waddr     = '0;
      mem_wdata     = '{key: req_chan.key, payload: req_chan.payload};
      mem_re        = 1'b0;
      mem_raddr     = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               res_status_in = STATUS_ERR;
               res_rec_in    = '0;
               key_in        = req_chan.key;
               state_in      = ST_POST;
               case (req_chan.action)
                  ACT_APPEND: begin
                     if (count_ff != CAP_CNT) begin
                        mem_we        = 1'b1;
                        mem_waddr     = phys(head_ff, count_ff[IDXW-1:0]);
                        count_in      = count_ff + CNTW'(1);
                        res_status_in = STATUS_OK;
                     end
                  end
                  ACT_INSERT: begin
                     if (count_ff != CAP_CNT) begin
                        head_in       = (head_ff == '0) ? LAST_IDX : head_ff - IDXW'(1);
                        mem_we        = 1'b1;
                        mem_waddr     = head_in;
                        count_in      = count_ff + CNTW'(1);
                        res_status_in = STATUS_OK;
                     end
                  end
                  ACT_RM_FRONT: begin
                     if (count_ff != '0) begin
                        head_in       = (head_ff == LAST_IDX) ? '0 : head_ff + IDXW'(1);
                        count_in      = count_ff - CNTW'(1);
                        res_status_in = STATUS_OK;
                     end
                  end
                  ACT_RM_END: begin
                     if (count_ff != '0) begin
                        count_in      = count_ff - CNTW'(1);
                        res_status_in = STATUS_OK;
                     end
                  end
                  ACT_READ: begin
                     if (pos_ok) begin
                        mem_re    = 1'b1;
                        mem_raddr = phys(head_ff, pos_idx);
                        state_in  = ST_READ;
                     end
                  end
                  ACT_FIND: begin
                     if (count_ff != '0) begin
                        mem_re    = 1'b1;
                        mem_raddr = phys(head_ff, last_idx);
                        idx_in    = last_idx;
                        state_in  = ST_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            res_status_in = STATUS_OK;
            res_rec_in    = mem_rdata;
            state_in      = ST_POST;
         end
         ST_SCAN: begin
            // mem_rdata holds the entry at idx_ff; the next read goes out meanwhile
            if (mem_rdata.key == key_ff) begin
               res_status_in = STATUS_OK;
               res_rec_in    = mem_rdata;
               state_in      = ST_POST;
            end else if (idx_ff == '0) begin
               state_in = ST_POST;
            end else begin
               idx_in    = idx_ff - IDXW'(1);
               mem_re    = 1'b1;
               mem_raddr = phys(head_ff, idx_in);
            end
         end
         ST_POST: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = out_load ? 1'b1 : (rsp_valid_ff && !rsp_chan.ready);
      rsp_status_in = out_load ? res_status_ff : rsp_status_ff;
      rsp_rec_in    = out_load ? res_rec_ff : rsp_rec_ff;
      rsp_count_in  = out_load ? CNT_OUT_W'(count_ff) : rsp_count_ff;
      rsp_full_in   = out_load ? (count_ff == CAP_CNT) : rsp_full_ff;
      rsp_empty_in  = out_load ? (count_ff == '0) : rsp_empty_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      key_ff        <= key_in;
      res_status_ff <= res_status_in;
      res_rec_ff    <= res_rec_in;
      rsp_status_ff <= rsp_status_in;
      rsp_rec_ff    <= rsp_rec_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_full_ff   <= rsp_full_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.found_key     = rsp_rec_ff.key;
   assign rsp_chan.found_payload = rsp_rec_ff.payload;
   assign rsp_chan.count         = rsp_count_ff;
   assign rsp_chan.full_res      = rsp_full_ff;
   assign rsp_chan.empty_res     = rsp_empty_ff;

   `SRLU_ASSERT(a_count_in_range, count_ff <= CAP_CNT)
   `SRLU_ASSERT(a_head_in_range, (IDXW + 1)'(head_ff) < CAP_WRAP)
   `SRLU_ASSERT(a_scan_below_count, (state_ff == ST_SCAN) |-> (idx_ff < count_ff))
   `SRLU_ASSERT_NEXT(a_count_only_on_accept, !req_fire, $stable(count_ff))
   `SRLU_ASSERT_NEXT(a_post_loads_output, out_load, rsp_valid_ff)

endmodule

/* bench/tb.sv */
module tb;
   import srl_pkg::*;

   localparam int LIST_DEPTH = 64;
   // action codes outside the defined set, the block must ignore them
   localparam logic [ACT_W-1:0] ACT_RESERVED_A = 3'd6;
   localparam logic [ACT_W-1:0] ACT_RESERVED_B = 3'd7;
   localparam int TOTAL_REQS = 1525;
   localparam int QUIET_TAIL = 150;

   typedef struct {
      logic [ACT_W-1:0] action;
      logic [KEY_W-1:0] key;
      logic [PAY_W-1:0] payload;
      logic [POS_W-1:0] position;
      bit               hold;
   } list_req_t;

   typedef struct {
      logic                 status;
      logic [KEY_W-1:0]     found_key;
      logic [PAY_W-1:0]     found_payload;
      logic [CNT_OUT_W-1:0] count;
      logic                 full_res;
      logic                 empty_res;
   } list_rsp_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   srl_req_if req_chan ();
   srl_rsp_if rsp_chan ();

   sequential_record_list_unit #(.CAPACITY(LIST_DEPTH)) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   list_req_t        pending_q[$];
   list_rsp_t        rsp_expect_q[$];
   rec_type          record_list[$];
   logic [KEY_W-1:0] gen_keys[$];
   bit               hold_next = 1'b0;
   list_req_t        cur_req;
   int               error_count = 0;
   int               accepted_n = 0;
   int               returned_n = 0;
   int               send_idle = 0;
   int               recv_idle = 0;

   // applies one request to the shadow list and returns the result it must produce
   function automatic list_rsp_t apply_list_op(input list_req_t r);
      list_rsp_t res;
      rec_type   rec;
      int        n;
      res = '{default: '0};
      res.status = STATUS_ERR;
      n = record_list.size();
      rec.key = r.key;
      rec.payload = r.payload;
      case (r.action)
         ACT_APPEND: begin
            if (n < LIST_DEPTH) begin
               record_list.push_back(rec);
               res.status = STATUS_OK;
            end
         end
         ACT_INSERT: begin
            if (n < LIST_DEPTH) begin
               record_list.push_front(rec);
               res.status = STATUS_OK;
            end
         end
         ACT_RM_FRONT: begin
            if (n > 0) begin
               void'(record_list.pop_front());
               res.status = STATUS_OK;
            end
         end
         ACT_RM_END: begin
            if (n > 0) begin
               void'(record_list.pop_back());
               res.status = STATUS_OK;
            end
         end
         ACT_READ: begin
            if (r.position >= 1 && r.position <= n) begin
               res.found_key = record_list[r.position - 1].key;
               res.found_payload = record_list[r.position - 1].payload;
               res.status = STATUS_OK;
            end
         end
         ACT_FIND: begin
            // nearest the end wins
            for (int i = n - 1; i >= 0; i--) begin
               if (record_list[i].key == r.key) begin
                  res.found_key = record_list[i].key;
                  res.found_payload = record_list[i].payload;
                  res.status = STATUS_OK;
                  break;
               end
            end
         end
         default: ;
      endcase
      n = record_list.size();
      res.count = n[CNT_OUT_W-1:0];
      res.full_res = (n == LIST_DEPTH);
      res.empty_res = (n == 0);
      return res;
   endfunction

   // queues a request and keeps a key-only view of the list for choosing targets
   task automatic push_req(input logic [ACT_W-1:0] act, input logic [KEY_W-1:0] k,
                           input logic [PAY_W-1:0] p, input logic [POS_W-1:0] pos);
      list_req_t r;
      r.action = act;
      r.key = k;
      r.payload = p;
      r.position = pos;
      r.hold = hold_next;
      hold_next = 1'b0;
      pending_q.push_back(r);
      case (act)
         ACT_APPEND: if (gen_keys.size() < LIST_DEPTH) gen_keys.push_back(k);
         ACT_INSERT: if (gen_keys.size() < LIST_DEPTH) gen_keys.push_front(k);
         ACT_RM_FRONT: if (gen_keys.size() > 0) void'(gen_keys.pop_front());
         ACT_RM_END: if (gen_keys.size() > 0) void'(gen_keys.pop_back());
         default: ;
      endcase
   endtask

   function automatic logic [KEY_W-1:0] pick_key();
      if ($urandom_range(0, 1) == 0) return KEY_W'($urandom_range(0, 15));
      return KEY_W'($urandom);
   endfunction

   function automatic logic [PAY_W-1:0] pick_payload();
      return {$urandom, $urandom};
   endfunction

   task automatic push_probe();
      int n;
      n = gen_keys.size();
      if ($urandom_range(0, 1) == 0) begin
         if (n > 0 && $urandom_range(0, 9) < 8)
            push_req(ACT_READ, pick_key(), pick_payload(), POS_W'($urandom_range(1, n)));
         else
            push_req(ACT_READ, pick_key(), pick_payload(), POS_W'($urandom_range(0, 127)));
      end else begin
         if (n > 0 && $urandom_range(0, 9) < 7)
            push_req(ACT_FIND, gen_keys[$urandom_range(0, n - 1)], pick_payload(),
                     POS_W'($urandom));
         else
            push_req(ACT_FIND, pick_key(), pick_payload(), POS_W'($urandom));
      end
   endtask

   task automatic push_store(input bit at_front);
      push_req(at_front ? ACT_INSERT : ACT_APPEND, pick_key(), pick_payload(),
               POS_W'($urandom));
   endtask

   task automatic push_remove(input bit at_front);
      push_req(at_front ? ACT_RM_FRONT : ACT_RM_END, pick_key(), pick_payload(),
               POS_W'($urandom));
   endtask

   initial begin
      // empty list: removes, read and find all fail
      push_req(ACT_RM_FRONT, '0, '0, '0);
      push_req(ACT_RM_END, '0, '0, '0);
      push_req(ACT_READ, '0, '0, 7'd1);
      push_req(ACT_FIND, '0, '0, '0);
      push_req(ACT_APPEND, 31'h7fffffff, 64'hffffffffffffffff, 7'd127);
      push_req(ACT_INSERT, '0, '0, '0);
      push_req(ACT_APPEND, 31'h2aaaaaaa, 64'h5555555555555555, 7'd42);
      push_req(ACT_INSERT, 31'h55555555, 64'haaaaaaaaaaaaaaaa, 7'd85);
      push_req(ACT_READ, '0, '0, 7'd0);
      push_req(ACT_READ, '0, '0, 7'd1);
      push_req(ACT_READ, '0, '0, 7'd4);
      push_req(ACT_READ, '0, '0, 7'd5);
      push_req(ACT_READ, '0, '0, 7'd127);
      push_req(ACT_FIND, 31'h7fffffff, '0, '0);
      push_req(ACT_FIND, '0, '0, '0);
      push_req(ACT_FIND, 31'h1234, '0, '0);
      // duplicate key, find must return the later one
      push_req(ACT_APPEND, '0, 64'h0123456789abcdef, '0);
      push_req(ACT_FIND, '0, '0, '0);
      push_req(ACT_RESERVED_A, pick_key(), pick_payload(), 7'd1);
      push_req(ACT_RESERVED_B, pick_key(), pick_payload(), 7'd2);
      push_req(ACT_RM_FRONT, '0, '0, '0);
      push_req(ACT_RM_END, '0, '0, '0);
      push_req(ACT_READ, '0, '0, 7'd1);
      hold_next = 1'b1;

      while (pending_q.size() < TOTAL_REQS) begin
         if ($urandom_range(0, 5) == 0) hold_next = 1'b1;
         case ($urandom_range(0, 2))
            0: begin
               while (gen_keys.size() < LIST_DEPTH) begin
                  if ($urandom_range(0, 4) == 0) push_probe();
                  else push_store(1'($urandom_range(0, 1)));
               end
               // stores into a full list
               repeat ($urandom_range(1, 3)) push_store(1'($urandom_range(0, 1)));
               push_req(ACT_READ, pick_key(), pick_payload(), POS_W'(LIST_DEPTH));
               push_probe();
            end
            1: begin
               while (gen_keys.size() > 0) begin
                  if ($urandom_range(0, 4) == 0) push_probe();
                  else push_remove(1'($urandom_range(0, 1)));
               end
               repeat ($urandom_range(1, 2)) push_remove(1'($urandom_range(0, 1)));
               push_probe();
            end
            default: begin
               repeat (30) begin
                  case ($urandom_range(0, 39))
                     0: push_req(($urandom_range(0, 1) == 0) ? ACT_RESERVED_A : ACT_RESERVED_B,
                                 pick_key(), pick_payload(), POS_W'($urandom));
                     1, 2, 3, 4, 5, 6, 7, 8, 9, 10: push_store(1'($urandom_range(0, 1)));
                     11, 12, 13, 14, 15, 16, 17, 18, 19:
                        push_remove(1'($urandom_range(0, 1)));
                     default: push_probe();
                  endcase
               end
            end
         endcase
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   // driver
   always @(posedge clock) begin
      logic send_valid;
      bit   quiet;
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.action <= ACT_APPEND;
         req_chan.key <= '0;
         req_chan.payload <= '0;
         req_chan.position <= '0;
      end else begin
         quiet = pending_q.size() < QUIET_TAIL;
         send_valid = req_chan.valid;
         if (req_chan.valid && req_chan.ready) begin
            rsp_expect_q.push_back(apply_list_op(cur_req));
            accepted_n++;
            send_valid = 1'b0;
         end
         if (!send_valid) begin
            if (send_idle > 0) begin
               send_idle--;
            end else if (pending_q.size() > 0 &&
                         (!pending_q[0].hold || rsp_expect_q.size() == 0)) begin
               cur_req = pending_q.pop_front();
               send_valid = 1'b1;
               req_chan.action <= cur_req.action;
               req_chan.key <= cur_req.key;
               req_chan.payload <= cur_req.payload;
               req_chan.position <= cur_req.position;
               // every third stretch of 100 transactions runs without gaps
               if (!quiet && (accepted_n % 300) < 200 && $urandom_range(0, 4) == 0)
                  send_idle = $urandom_range(1, 9);
            end
         end
         req_chan.valid <= send_valid;
      end
   end

   // monitor and response-side stalls
   always @(posedge clock) begin
      list_rsp_t want;
      bit        quiet;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         quiet = pending_q.size() < QUIET_TAIL;
         if (rsp_chan.valid && rsp_chan.ready) begin
            returned_n++;
            if (rsp_expect_q.size() == 0) begin
               $error("result with nothing outstanding");
               error_count++;
            end else begin
               want = rsp_expect_q.pop_front();
               if (rsp_chan.status !== want.status) begin
                  $error("status: expected %0h, got %0h", want.status, rsp_chan.status);
                  error_count++;
               end
               if (rsp_chan.found_key !== want.found_key) begin
                  $error("found_key: expected %0h, got %0h", want.found_key,
                         rsp_chan.found_key);
                  error_count++;
               end
               if (rsp_chan.found_payload !== want.found_payload) begin
                  $error("found_payload: expected %0h, got %0h", want.found_payload,
                         rsp_chan.found_payload);
                  error_count++;
               end
               if (rsp_chan.count !== want.count) begin
                  $error("count: expected %0d, got %0d", want.count, rsp_chan.count);
                  error_count++;
               end
               if (rsp_chan.full_res !== want.full_res) begin
                  $error("full_res: expected %0h, got %0h", want.full_res,
                         rsp_chan.full_res);
                  error_count++;
               end
               if (rsp_chan.empty_res !== want.empty_res) begin
                  $error("empty_res: expected %0h, got %0h", want.empty_res,
                         rsp_chan.empty_res);
                  error_count++;
               end
            end
         end
         if (recv_idle > 0) begin
            recv_idle--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
            if (!quiet && ((returned_n + 150) % 300) < 200 && $urandom_range(0, 5) == 0)
               recv_idle = $urandom_range(1, 9);
         end
      end
   end

   initial begin
      do @(negedge clock);
      while (reset || pending_q.size() != 0 || req_chan.valid || rsp_expect_q.size() != 0);
      // let any stray result show up
      repeat (LIST_DEPTH + 20) @(negedge clock);
      if (error_count == 0 && rsp_expect_q.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
